// ===== rtl/ftsq_pkg.sv =====
// shared constants, types and sequencing tables for the pll tuning sequencer
package ftsq_pkg;

  localparam int NUM_SYNTHS = 2;
  localparam int NUM_REGS   = 13;
  localparam int IMG_DEPTH  = NUM_SYNTHS * NUM_REGS;
  localparam int IMG_AW     = $clog2(IMG_DEPTH);

  localparam logic [27:0] REF_RESET = 28'd26000000;
  localparam logic [39:0] VCO_MIN   = 40'd3400000000;

  localparam int DVD_W = 74;
  localparam int DSR_W = 40;
  localparam int CNT_W = 7;

  localparam logic [1:0] FN_TUNE  = 2'd0;
  localparam logic [1:0] FN_INIT  = 2'd1;
  localparam logic [1:0] FN_PDOWN = 2'd2;

  localparam logic [3:0] MD_NONE    = 4'd0;
  localparam logic [3:0] MD_DEFAULT = 4'd1;
  localparam logic [3:0] MD_PD4     = 4'd2;
  localparam logic [3:0] MD_PD6     = 4'd3;
  localparam logic [3:0] MD_T0      = 4'd4;
  localparam logic [3:0] MD_T1      = 4'd5;
  localparam logic [3:0] MD_T2      = 4'd6;
  localparam logic [3:0] MD_T4      = 4'd7;
  localparam logic [3:0] MD_T6      = 4'd8;
  localparam logic [3:0] MD_T9      = 4'd9;
  localparam logic [3:0] MD_T10     = 4'd10;
  localparam logic [3:0] MD_SET4    = 4'd11;
  localparam logic [3:0] MD_CLR4    = 4'd12;
  localparam logic [3:0] MD_CLR21   = 4'd13;
  localparam logic [3:0] MD_SET21   = 4'd14;

  localparam logic [3:0] AOP_NONE = 4'd0;
  localparam logic [3:0] AOP_SEL  = 4'd1;
  localparam logic [3:0] AOP_RDIV = 4'd2;
  localparam logic [3:0] AOP_RSET = 4'd3;
  localparam logic [3:0] AOP_MUL  = 4'd4;
  localparam logic [3:0] AOP_NDIV = 4'd5;
  localparam logic [3:0] AOP_NSET = 4'd6;
  localparam logic [3:0] AOP_MDIV = 4'd7;
  localparam logic [3:0] AOP_MSET = 4'd8;
  localparam logic [3:0] AOP_PMUL = 4'd9;
  localparam logic [3:0] AOP_FDIV = 4'd10;
  localparam logic [3:0] AOP_FSET = 4'd11;
  localparam logic [3:0] AOP_BDIV = 4'd12;
  localparam logic [3:0] AOP_BSET = 4'd13;
  localparam logic [3:0] AOP_TDIV = 4'd14;
  localparam logic [3:0] AOP_TSET = 4'd15;

  localparam logic [3:0] AIDX_LAST = 4'd13;

  typedef struct packed {
    logic [3:0] addr;
    logic [3:0] mode;
    logic       emit;
    logic       wait_f;
    logic       last_f;
    logic       fin;
  } step_t;

  typedef struct packed {
    logic       load_in;
    logic [3:0] aop;
    logic       rd;
    logic       wr;
    step_t      step;
  } dp_cmd_t;

  typedef struct packed {
    logic sel_done;
    logic div_busy;
    logic out_busy;
  } dp_stat_t;

  function automatic logic [31:0] default_word(input logic [3:0] addr);
    logic [31:0] w;
    case (addr)
      4'd0:    w = 32'h00200000;
      4'd4:    w = 32'h30000180;
      4'd5:    w = 32'h00800025;
      4'd6:    w = 32'h350040F0;
      4'd7:    w = 32'h12000000;
      4'd8:    w = 32'h102D0428;
      4'd10:   w = 32'h00C00030;
      4'd11:   w = 32'h0061300B;
      4'd12:   w = 32'h00000410;
      default: w = 32'h00000000;
    endcase
    return w;
  endfunction

  function automatic logic is_div(input logic [3:0] aop);
    return (aop == AOP_RDIV) || (aop == AOP_NDIV) || (aop == AOP_MDIV) ||
           (aop == AOP_FDIV) || (aop == AOP_BDIV) || (aop == AOP_TDIV);
  endfunction

  function automatic logic [3:0] arith_op(input logic [3:0] aidx);
    logic [3:0] op;
    case (aidx)
      4'd0:    op = AOP_RDIV;
      4'd1:    op = AOP_RSET;
      4'd2:    op = AOP_MUL;
      4'd3:    op = AOP_NDIV;
      4'd4:    op = AOP_NSET;
      4'd5:    op = AOP_MDIV;
      4'd6:    op = AOP_MSET;
      4'd7:    op = AOP_PMUL;
      4'd8:    op = AOP_FDIV;
      4'd9:    op = AOP_FSET;
      4'd10:   op = AOP_BDIV;
      4'd11:   op = AOP_BSET;
      4'd12:   op = AOP_TDIV;
      4'd13:   op = AOP_TSET;
      default: op = AOP_NONE;
    endcase
    return op;
  endfunction

  function automatic step_t mk(input logic [3:0] addr, input logic [3:0] mode,
                               input logic emit, input logic fin);
    step_t s;
    s.addr   = addr;
    s.mode   = mode;
    s.emit   = emit;
    s.wait_f = fin;
    s.last_f = fin;
    s.fin    = fin;
    return s;
  endfunction

  function automatic step_t step_of(input logic [1:0] func, input logic [3:0] idx);
    step_t s;
    s = '0;
    case (func)
      FN_INIT: begin
        s = mk(4'd12 - idx, MD_DEFAULT, 1'b1, 1'b0);
        s.last_f = (idx == 4'd12);
        s.fin    = (idx == 4'd12);
      end
      FN_PDOWN: begin
        case (idx)
          4'd0:    s = mk(4'd4, MD_PD4, 1'b0, 1'b0);
          4'd1:    s = mk(4'd6, MD_PD6, 1'b0, 1'b0);
          default: begin
            s = mk(4'd14 - idx, MD_NONE, 1'b1, 1'b0);
            s.last_f = (idx == 4'd14);
            s.fin    = (idx == 4'd14);
          end
        endcase
      end
      FN_TUNE: begin
        case (idx)
          4'd0:    s = mk(4'd0, MD_T0, 1'b0, 1'b0);
          4'd1:    s = mk(4'd1, MD_T1, 1'b0, 1'b0);
          4'd2:    s = mk(4'd2, MD_T2, 1'b0, 1'b0);
          4'd3:    s = mk(4'd4, MD_T4, 1'b0, 1'b0);
          4'd4:    s = mk(4'd6, MD_T6, 1'b0, 1'b0);
          4'd5:    s = mk(4'd9, MD_T9, 1'b0, 1'b0);
          4'd6:    s = mk(4'd10, MD_T10, 1'b0, 1'b0);
          4'd7:    s = mk(4'd6, MD_NONE, 1'b1, 1'b0);
          4'd8:    s = mk(4'd9, MD_NONE, 1'b1, 1'b0);
          4'd9:    s = mk(4'd10, MD_NONE, 1'b1, 1'b0);
          4'd10:   s = mk(4'd4, MD_SET4, 1'b1, 1'b0);
          4'd11:   s = mk(4'd2, MD_NONE, 1'b1, 1'b0);
          4'd12:   s = mk(4'd1, MD_NONE, 1'b1, 1'b0);
          4'd13:   s = mk(4'd0, MD_CLR21, 1'b1, 1'b0);
          4'd14:   s = mk(4'd4, MD_CLR4, 1'b1, 1'b0);
          default: s = mk(4'd0, MD_SET21, 1'b1, 1'b1);
        endcase
      end
      default: s = mk(4'd0, MD_NONE, 1'b0, 1'b1);
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/ftsq_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
module ftsq_div
  import ftsq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dvd,
  input  logic [DSR_W-1:0] dsr,
  input  logic [CNT_W-1:0] cnt,
  output logic             busy,
  output logic [DVD_W-1:0] quo,
  output logic [DSR_W-1:0] rem
);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] dvd_r, quo_r;
  logic [DSR_W-1:0] dsr_r, rem_r;
  logic [DSR_W:0]   trial, diff;
  logic             ge;

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign ge    = trial >= {1'b0, dsr_r};
  assign diff  = trial - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= cnt;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == 7'd1) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dvd;
      dsr_r <= dsr;
      quo_r <= '0;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      quo_r <= {quo_r[DVD_W-2:0], ge};
      rem_r <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

// ===== rtl/ftsq_dp.sv =====
// datapath: divider arithmetic, register image memory and output word register
module ftsq_dp
  import ftsq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic        in_which,
  input  logic [32:0] in_freq,
  input  logic        cfg_wr_en,
  input  logic [27:0] cfg_wr_data,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  output logic [1:0]  out_tuser,
  output logic        out_tlast
);

  logic [27:0] ref_r, refe;
  logic        which_r;
  logic [2:0]  sel_r;
  logic [39:0] vco_r;
  logic [9:0]  r_r;
  logic [49:0] num_r;
  logic [29:0] r1m_r, r06_r;
  logic [31:0] r24_r;
  logic [15:0] nint_r;
  logic [23:0] frac1_r;
  logic [27:0] rem2_r;
  logic [13:0] mod2_r, frac2_r;
  logic [41:0] prod_r;
  logic [7:0]  band_r;
  logic [9:0]  tmo_r;

  logic             div_start, div_busy;
  logic [DVD_W-1:0] div_dvd, div_quo;
  logic [DSR_W-1:0] div_dsr, div_rem;
  logic [CNT_W-1:0] div_cnt;
  logic [32:0]      need;
  logic [40:0]      rdiv_dvd;
  logic [30:0]      tdiv_dvd;
  logic             sel_done;

  logic [31:0]       mem [IMG_DEPTH];
  logic [IMG_DEPTH-1:0] vld_r;
  logic [IMG_AW-1:0] img_addr;
  logic [31:0]       rd_q_r, old_w, new_w;
  logic              rd_vld_r;
  logic [3:0]        rd_addr_r;
  logic              emit_go;

  logic        out_valid_r;
  logic [31:0] out_word_r;
  logic        out_wait_r, out_sel_r, out_last_r;

  assign refe     = (ref_r == '0) ? 28'd1 : ref_r;
  assign need     = 33'(refe) * 33'd23;
  assign rdiv_dvd = 41'(need) + 41'(vco_r) - 41'd1;
  assign tdiv_dvd = 31'(refe) + 31'(r06_r) - 31'd1;
  assign sel_done = (vco_r >= VCO_MIN) || (sel_r == 3'd7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= REF_RESET;
    end else if (cfg_wr_en) begin
      ref_r <= cfg_wr_data;
    end
  end

  assign div_start = is_div(cmd.aop);

  always_comb begin
    div_dvd = '0;
    div_dsr = '0;
    div_cnt = '0;
    case (cmd.aop)
      AOP_RDIV: begin
        div_dvd = {rdiv_dvd, 33'd0};
        div_dsr = vco_r;
        div_cnt = 7'd41;
      end
      AOP_NDIV: begin
        div_dvd = {num_r, 24'd0};
        div_dsr = 40'(refe);
        div_cnt = 7'd74;
      end
      AOP_MDIV: begin
        div_dvd = {refe, 46'd0};
        div_dsr = 40'(r1m_r);
        div_cnt = 7'd28;
      end
      AOP_FDIV: begin
        div_dvd = {prod_r, 32'd0};
        div_dsr = 40'(refe);
        div_cnt = 7'd42;
      end
      AOP_BDIV: begin
        div_dvd = {refe, 46'd0};
        div_dsr = 40'(r24_r);
        div_cnt = 7'd28;
      end
      AOP_TDIV: begin
        div_dvd = {tdiv_dvd, 43'd0};
        div_dsr = 40'(r06_r);
        div_cnt = 7'd31;
      end
      default: ;
    endcase
  end

  ftsq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dvd   (div_dvd),
    .dsr   (div_dsr),
    .cnt   (div_cnt),
    .busy  (div_busy),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      which_r <= in_which;
      vco_r   <= 40'(in_freq);
      sel_r   <= '0;
    end else begin
      case (cmd.aop)
        AOP_SEL: begin
          if (!sel_done) begin
            sel_r <= sel_r + 3'd1;
            vco_r <= {vco_r[38:0], 1'b0};
          end
        end
        AOP_RSET: begin
          if (div_quo == '0) begin
            r_r <= 10'd1;
          end else if (div_quo[DVD_W-1:10] != '0) begin
            r_r <= 10'd1023;
          end else begin
            r_r <= div_quo[9:0];
          end
        end
        AOP_MUL: begin
          num_r <= 50'(vco_r) * 50'(r_r);
          r1m_r <= 30'(r_r) * 30'd1000000;
          r24_r <= 32'(r_r) * 32'd2400000;
          r06_r <= 30'(r_r) * 30'd600000;
        end
        AOP_NSET: begin
          nint_r  <= div_quo[39:24];
          frac1_r <= div_quo[23:0];
          rem2_r  <= div_rem[27:0];
        end
        AOP_MSET: mod2_r  <= div_quo[13:0];
        AOP_PMUL: prod_r  <= 42'(rem2_r) * 42'(mod2_r);
        AOP_FSET: frac2_r <= div_quo[13:0];
        AOP_BSET: begin
          if (div_quo[DVD_W-1:8] != '0 || div_quo[7:0] == 8'd255) begin
            band_r <= 8'd255;
          end else begin
            band_r <= div_quo[7:0] + 8'd1;
          end
        end
        AOP_TSET: tmo_r <= div_quo[9:0];
        default: ;
      endcase
    end
  end

  assign img_addr = IMG_AW'(which_r) * IMG_AW'(NUM_REGS) + IMG_AW'(cmd.step.addr);

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_q_r    <= mem[img_addr];
      rd_addr_r <= cmd.step.addr;
    end
    if (cmd.wr) begin
      mem[img_addr] <= new_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.rd) begin
        rd_vld_r <= vld_r[img_addr];
      end
      if (cmd.wr) begin
        vld_r[img_addr] <= 1'b1;
      end
    end
  end

  assign old_w = rd_vld_r ? rd_q_r : default_word(rd_addr_r);

  always_comb begin
    new_w = old_w;
    case (cmd.step.mode)
      MD_DEFAULT: new_w = default_word(rd_addr_r);
      MD_PD4: begin
        new_w[29:27] = 3'd0;
        new_w[5]     = 1'b1;
        new_w[6]     = 1'b1;
      end
      MD_PD6: begin
        new_w[9] = 1'b0;
        new_w[6] = 1'b0;
      end
      MD_T0: begin
        new_w[19:4] = nint_r;
        new_w[20]   = 1'b0;
        new_w[21]   = 1'b1;
      end
      MD_T1: new_w[27:4] = frac1_r;
      MD_T2: begin
        new_w[17:4]  = mod2_r;
        new_w[31:18] = frac2_r;
      end
      MD_T4: begin
        new_w[24:15] = r_r;
        new_w[25]    = 1'b0;
        new_w[26]    = 1'b0;
      end
      MD_T6: new_w[23:21] = sel_r;
      MD_T9: begin
        new_w[8:4]   = 5'd12;
        new_w[13:9]  = 5'd30;
        new_w[23:14] = tmo_r;
        new_w[31:24] = band_r;
      end
      MD_T10:   new_w[13:6] = 8'd65;
      MD_SET4:  new_w[4]    = 1'b1;
      MD_CLR4:  new_w[4]    = 1'b0;
      MD_CLR21: new_w[21]   = 1'b0;
      MD_SET21: new_w[21]   = 1'b1;
      default: ;
    endcase
  end

  assign emit_go = cmd.wr && cmd.step.emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_word_r <= {new_w[31:4], cmd.step.addr};
      out_wait_r <= cmd.step.wait_f;
      out_last_r <= cmd.step.last_f;
      out_sel_r  <= which_r;
    end
  end

  assign out_tvalid     = out_valid_r;
  assign out_tdata      = out_word_r;
  assign out_tuser      = {out_wait_r, out_sel_r};
  assign out_tlast      = out_last_r;
  assign stat.sel_done  = sel_done;
  assign stat.div_busy  = div_busy;
  assign stat.out_busy  = out_valid_r && !out_tready;

endmodule

// ===== rtl/ftsq_ctrl.sv =====
// controller: command sequencing over arithmetic ops and image read-modify-write steps
module ftsq_ctrl
  import ftsq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [1:0] in_func,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SEL   = 3'd1;
  localparam logic [2:0] ST_ARITH = 3'd2;
  localparam logic [2:0] ST_DWAIT = 3'd3;
  localparam logic [2:0] ST_RD    = 3'd4;
  localparam logic [2:0] ST_MOD   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [1:0] func_r, func_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic [3:0] aidx_r, aidx_nxt;
  logic [3:0] aop;

  assign aop = arith_op(aidx_r);

  always_comb begin
    state_nxt   = state_r;
    func_nxt    = func_r;
    idx_nxt     = idx_r;
    aidx_nxt    = aidx_r;
    in_tready   = 1'b0;
    cmd.load_in = 1'b0;
    cmd.aop     = AOP_NONE;
    cmd.rd      = 1'b0;
    cmd.wr      = 1'b0;
    cmd.step    = step_of(func_r, idx_r);
    case (state_r)
      ST_IDLE: begin
        in_tready = rst_n;
        if (in_tvalid && in_tready) begin
          cmd.load_in = 1'b1;
          func_nxt    = in_func;
          idx_nxt     = '0;
          aidx_nxt    = '0;
          case (in_func)
            FN_TUNE:  state_nxt = ST_SEL;
            FN_INIT:  state_nxt = ST_RD;
            FN_PDOWN: state_nxt = ST_RD;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SEL: begin
        cmd.aop = AOP_SEL;
        if (stat.sel_done) begin
          state_nxt = ST_ARITH;
        end
      end
      ST_ARITH: begin
        cmd.aop = aop;
        if (is_div(aop)) begin
          aidx_nxt  = aidx_r + 4'd1;
          state_nxt = ST_DWAIT;
        end else if (aidx_r == AIDX_LAST) begin
          state_nxt = ST_RD;
        end else begin
          aidx_nxt = aidx_r + 4'd1;
        end
      end
      ST_DWAIT: begin
        if (!stat.div_busy) begin
          state_nxt = ST_ARITH;
        end
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        if (!(cmd.step.emit && stat.out_busy)) begin
          cmd.wr = 1'b1;
          if (cmd.step.fin) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + 4'd1;
            state_nxt = ST_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      func_r  <= FN_TUNE;
      idx_r   <= '0;
      aidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      func_r  <= func_nxt;
      idx_r   <= idx_nxt;
      aidx_r  <= aidx_nxt;
    end
  end

endmodule

// ===== rtl/frac_n_pll_tuning_sequencer_unit.sv =====
// top level of the fractional-n pll tuning sequencer
// one command at a time: init, power down or tune; tune is set by the bit-serial divider
// (244 quotient bits over six divides) and vco search
// each image step reads the image, then modifies and writes it, waiting on output stalls
// reset loads the default image for both synthesizers and 26 MHz reference, no words emitted
module frac_n_pll_tuning_sequencer_unit
  import ftsq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // freq_hz
  input  logic [2:0]  in_tuser,   // func, which_synth
  input  logic        cfg_wr_en,
  input  logic [27:0] cfg_wr_data,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // spi_word
  output logic [1:0]  out_tuser,  // synth_select, wait_first
  output logic        out_tlast
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ftsq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_func   (in_tuser[1:0]),
    .stat      (stat),
    .cmd       (cmd)
  );

  ftsq_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_which    (in_tuser[2]),
    .in_freq     (in_tdata[32:0]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  a_init_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[1:0] == FN_INIT |=> !in_tready)
    else $error("init command did not occupy the sequencer");

  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[3:0] < 4'(NUM_REGS))
    else $error("emitted word carries a register address out of range");

  a_wait_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast)
    else $error("wait flag on a word that is not the last of its run");

endmodule

// ===== tb/tb.sv =====
// testbench for the pll tuning sequencer: command stimulus, image predictor and word checker
module tb;
  import ftsq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FN_UNUSED = 2'd3;
  localparam int SETTLE = 400;

  typedef struct packed {
    logic        synth;
    logic [31:0] word;
    logic        wait_f;
    logic        last_f;
  } spi_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        cfg_wr_en = 1'b0;
  logic [27:0] cfg_wr_data = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  frac_n_pll_tuning_sequencer_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  logic [31:0] img [NUM_SYNTHS][NUM_REGS];
  logic [27:0] ref_hz;
  spi_word_t   expected_words[$];
  int          errors = 0;
  bit          no_idle = 0;
  int          hold_cycles = 0;
  bit          word_taken = 0;

  function automatic logic [31:0] put(input logic [31:0] w, input longint unsigned v,
                                      input logic [31:0] mask, input int sh);
    return (w & ~(mask << sh)) | ((v[31:0] & mask) << sh);
  endfunction

  function automatic void load_image(input int s);
    img[s][0] = 32'h00200000; img[s][1] = 32'h0; img[s][2] = 32'h0; img[s][3] = 32'h0;
    img[s][4] = 32'h30000180; img[s][5] = 32'h00800025; img[s][6] = 32'h350040F0;
    img[s][7] = 32'h12000000; img[s][8] = 32'h102D0428; img[s][9] = 32'h0;
    img[s][10] = 32'h00C00030; img[s][11] = 32'h0061300B; img[s][12] = 32'h00000410;
  endfunction

  function automatic void push_word(input int s, input int a, input bit w, input bit l);
    spi_word_t e;
    e.synth = s[0];
    e.word = (img[s][a] & ~32'hF) | a[3:0];
    e.wait_f = w;
    e.last_f = l;
    expected_words.push_back(e);
  endfunction

  function automatic void predict_words(input logic [1:0] fn, input int s,
                                        input longint unsigned f);
    longint unsigned rf, vco, need, r, num, nint, rem, frac1, rem2, mod2, frac2, band, tmo;
    int sel;
    if (fn == FN_INIT || fn == FN_PDOWN) begin
      if (fn == FN_INIT) load_image(s);
      else begin
        img[s][4] = put(img[s][4], 0, 7, 27);
        img[s][4] = put(img[s][4], 1, 1, 5);
        img[s][4] = put(img[s][4], 1, 1, 6);
        img[s][6] = put(img[s][6], 0, 1, 9);
        img[s][6] = put(img[s][6], 0, 1, 6);
      end
      for (int a = NUM_REGS - 1; a >= 0; a--) push_word(s, a, 0, a == 0);
    end else if (fn == FN_TUNE) begin
      rf = (ref_hz == 0) ? 1 : ref_hz;
      sel = 0;
      vco = f;
      while (vco < 64'd3400000000 && sel < 7) begin
        sel++;
        vco = f << sel;
      end
      need = 23 * rf;
      if (vco == 0) r = 1023;
      else begin
        r = (need + vco - 1) / vco;
        if (r < 1) r = 1;
        if (r > 1023) r = 1023;
      end
      num = vco * r;
      nint = num / rf;
      rem = num % rf;
      frac1 = (rem << 24) / rf;
      rem2 = (rem << 24) % rf;
      mod2 = rf / (r * 1000000);
      frac2 = (rem2 * mod2) / rf;
      band = rf / (2400000 * r) + 1;
      if (band > 255) band = 255;
      tmo = (rf + 600000 * r - 1) / (600000 * r);
      img[s][0] = put(img[s][0], nint, 32'hFFFF, 4);
      img[s][0] = put(img[s][0], 0, 1, 20);
      img[s][0] = put(img[s][0], 1, 1, 21);
      img[s][1] = put(img[s][1], frac1, 32'hFFFFFF, 4);
      img[s][2] = put(img[s][2], mod2, 32'h3FFF, 4);
      img[s][2] = put(img[s][2], frac2, 32'h3FFF, 18);
      img[s][4] = put(img[s][4], r, 32'h3FF, 15);
      img[s][4] = put(img[s][4], 0, 1, 25);
      img[s][4] = put(img[s][4], 0, 1, 26);
      img[s][6] = put(img[s][6], sel, 7, 21);
      img[s][9] = put(img[s][9], 12, 32'h1F, 4);
      img[s][9] = put(img[s][9], 30, 32'h1F, 9);
      img[s][9] = put(img[s][9], tmo, 32'h3FF, 14);
      img[s][9] = put(img[s][9], band, 32'hFF, 24);
      img[s][10] = put(img[s][10], 65, 32'hFF, 6);
      push_word(s, 6, 0, 0);
      push_word(s, 9, 0, 0);
      push_word(s, 10, 0, 0);
      img[s][4] = put(img[s][4], 1, 1, 4);
      push_word(s, 4, 0, 0);
      push_word(s, 2, 0, 0);
      push_word(s, 1, 0, 0);
      img[s][0] = put(img[s][0], 0, 1, 21);
      push_word(s, 0, 0, 0);
      img[s][4] = put(img[s][4], 0, 1, 4);
      push_word(s, 4, 0, 0);
      img[s][0] = put(img[s][0], 1, 1, 21);
      push_word(s, 0, 1, 1);
    end
  endfunction

  // receiver: random stalls per word, plus long hold-off on request
  int rx_wait = 0;
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_tready <= 1'b0;
    end else if (word_taken && !no_idle) begin
      word_taken = 0;
      rx_wait = $urandom_range(0, 5);
      out_tready <= (rx_wait == 0);
    end else if (rx_wait > 0) begin
      word_taken = 0;
      rx_wait--;
      out_tready <= (rx_wait == 0);
    end else begin
      word_taken = 0;
      out_tready <= 1'b1;
    end
  end

  // word checker, sampled mid-cycle ahead of the accepting edge
  always @(negedge clk) begin
    spi_word_t e;
    if (rst_n && out_tvalid && out_tready) begin
      word_taken = 1;
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %h", out_tdata);
      end else begin
        e = expected_words.pop_front();
        if (out_tdata !== e.word || out_tuser[0] !== e.synth ||
            out_tuser[1] !== e.wait_f || out_tlast !== e.last_f) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp word %h synth %b wait %b last %b, got %h %b %b %b",
                     e.word, e.synth, e.wait_f, e.last_f,
                     out_tdata, out_tuser[0], out_tuser[1], out_tlast);
        end
      end
    end
  end

  task automatic send_cmd(input logic [1:0] fn, input logic s, input logic [32:0] f);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, f};
    in_tuser <= {s, fn};
    forever begin
      @(negedge clk);
      if (in_tready) break;
    end
    @(posedge clk);
    predict_words(fn, s, f);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_ref(input logic [27:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    ref_hz = v;
  endtask

  function automatic logic [32:0] rand_freq();
    logic [63:0] x;
    x = {$urandom, $urandom};
    if ($urandom_range(0, 9) == 0) return x[32:0];
    return 33'(64'd54000000 + x % 64'd4346000001);
  endfunction

  task automatic test_commands();
    send_cmd(FN_INIT, 0, 0);
    send_cmd(FN_INIT, 1, '1);
    send_cmd(FN_PDOWN, 0, 0);
    send_cmd(FN_TUNE, 0, 33'd54000000);
    send_cmd(FN_TUNE, 1, 33'd4400000000);
    send_cmd(FN_TUNE, 0, 33'd3400000000);
    send_cmd(FN_TUNE, 1, 33'd3399999999);
    send_cmd(FN_TUNE, 0, 33'd0);
    send_cmd(FN_TUNE, 1, 33'd1);
    send_cmd(FN_TUNE, 0, '1);
    send_cmd(FN_UNUSED, 0, 33'h155555555);
    send_cmd(FN_UNUSED, 1, 33'h0AAAAAAAA);
    send_cmd(FN_PDOWN, 1, 0);
    send_cmd(FN_TUNE, 1, 33'd1000000000);
    send_cmd(FN_PDOWN, 1, 0);
    send_cmd(FN_INIT, 0, 0);
  endtask

  task automatic test_reference();
    logic [27:0] refs [5] = '{28'd10000000, 28'd250000000, 28'd0, 28'hFFFFFFF, 28'd26000000};
    foreach (refs[i]) begin
      write_ref(refs[i]);
      send_cmd(FN_TUNE, 0, 33'd54000000);
      send_cmd(FN_TUNE, 1, 33'd4400000000);
      send_cmd(FN_TUNE, $urandom_range(0, 1), rand_freq());
      send_cmd(FN_TUNE, 0, 33'd0);
    end
  endtask

  task automatic test_backpressure();
    drain();
    hold_cycles = 1500;
    no_idle = 1;
    send_cmd(FN_INIT, 0, 0);
    send_cmd(FN_PDOWN, 1, 0);
    send_cmd(FN_INIT, 1, 0);
    send_cmd(FN_TUNE, 0, rand_freq());
    send_cmd(FN_INIT, 0, 0);
    no_idle = 0;
  endtask

  task automatic test_random(input int count);
    int k;
    for (int i = 0; i < count; i++) begin
      no_idle = (i >= count / 2 && i < count / 2 + 20);
      k = $urandom_range(0, 99);
      if (k < 65) send_cmd(FN_TUNE, $urandom_range(0, 1), rand_freq());
      else if (k < 80) send_cmd(FN_INIT, $urandom_range(0, 1), rand_freq());
      else if (k < 95) send_cmd(FN_PDOWN, $urandom_range(0, 1), rand_freq());
      else send_cmd(FN_UNUSED, $urandom_range(0, 1), rand_freq());
      if (i == count / 3) begin
        write_ref(28'($urandom_range(10000000, 250000000)));
      end
    end
    no_idle = 0;
  endtask

  initial begin
    load_image(0);
    load_image(1);
    ref_hz = REF_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_commands();
    test_reference();
    test_backpressure();
    test_random(160);
    drain();
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
